// ===== hw/rtl/wrr_pkg.sv =====
// Shared types and constants for the windowed request retransmitter.
package wrr_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int ID_W    = 16;
    localparam int TICK_W  = 16;
    localparam int CLK_W   = 32;
    localparam int CNT_W   = 5;
    localparam int KIND_W  = 2;
    localparam int NEXT_W  = 17;
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NEW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACC  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_STAT = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_LAST_ID = 2'd0;
    localparam logic [1:0] REG_WINDOW  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam logic [ID_W-1:0]   RST_LAST_ID = 16'd0;
    localparam logic [CNT_W-1:0]  RST_WINDOW  = 5'd10;
    localparam logic [TICK_W-1:0] RST_TIMEOUT = 16'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEW,
        S_P1,
        S_ACC,
        S_P2,
        S_STAT
    } t_state;

endpackage

// ===== hw/rtl/windowed_request_retransmitter.sv =====
// Windowed request retransmitter: requesting side of a selective-repeat transfer.
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall      | mode, response_id, elapsed_ticks
//  out     | from block| o_out_valid / i_out_stall    | kind, chunk_id, outstanding, done_res,
//          |           |                              | last
//  cfg     | to block  | APB psel/penable/pwrite      | last_chunk_id, window_limit, timeout
//
// Each input word is taken in the idle state; the input then stalls until its status result
// is emitted. Between the two come a new-request and an accepted result where they apply and
// full rotations of the outstanding table through its head slot (an update pass when a
// request is added or a response meets entries, then a timeout pass when entries remain).
// Reset is synchronous and clears the control state and registers; the table itself has no
// reset, only entries below the count are ever looked at. A result that finds the output
// register still full waits until it is free.
module windowed_request_retransmitter #(
    parameter int WINDOW_DEPTH = wrr_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_in_mode,
    input  logic [wrr_pkg::ID_W-1:0]      i_in_response_id,
    input  logic [wrr_pkg::TICK_W-1:0]    i_in_elapsed_ticks,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wrr_pkg::KIND_W-1:0]    o_out_kind,
    output logic [wrr_pkg::ID_W-1:0]      o_out_chunk_id,
    output logic [wrr_pkg::CNT_W-1:0]     o_out_outstanding,
    output logic                          o_out_done_res,
    output logic                          o_out_last,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wrr_pkg::CFG_AW-1:0]    paddr,
    input  logic [wrr_pkg::CFG_DW-1:0]    pwdata,
    output logic [wrr_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);
    import wrr_pkg::*;

    // count holds 0..WINDOW_DEPTH; compares run in LW bits
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int TW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LW = (CW > CNT_W) ? CW : CNT_W;
    localparam int LA = (WINDOW_DEPTH > 1) ? 1 : 0;   // look-ahead slot
    localparam logic [TW-1:0] STEP_LAST = TW'(WINDOW_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH_L   = LW'(WINDOW_DEPTH);

    // configuration registers
    logic [ID_W-1:0]   r_last_id;
    logic [CNT_W-1:0]  r_win;
    logic [TICK_W-1:0] r_tmo;

    // step state
    t_state            r_state, n_state;
    logic [CLK_W-1:0]  r_clock, n_clock;
    logic [NEXT_W-1:0] r_next, n_next;
    logic [CW-1:0]     r_count, n_count;
    logic              r_app, n_app;       // a new entry joins in this step
    logic [CW-1:0]     r_app_pos, n_app_pos;
    logic [ID_W-1:0]   r_new_id, n_new_id;
    logic              r_mode, n_mode;
    logic [ID_W-1:0]   r_rid, n_rid;
    logic [TW-1:0]     r_step, n_step;
    logic              r_drop, n_drop;     // response matched earlier in pass

    // outstanding table, rotated one slot per cycle through slot 0 while not held for output
    logic [ID_W-1:0]   r_eid [WINDOW_DEPTH];
    logic [CLK_W-1:0]  r_est [WINDOW_DEPTH];
    logic              rot;
    logic [ID_W-1:0]   tail_id;
    logic [CLK_W-1:0]  tail_st;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [ID_W-1:0]   r_out_id;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_done, r_out_last;
    logic              emit;
    logic [KIND_W-1:0] e_kind;
    logic [ID_W-1:0]   e_id;
    logic [CNT_W-1:0]  e_cnt;
    logic              e_done, e_last;

    // shared decode
    logic              accept, out_free, cfg_wr;
    logic [LW-1:0]     cnt_l, step_l, step1_l, app_l, lim_l, cnt_inc_l, cnt_dec_l;
    logic              can_app, in_use, past_last, pass_end;
    logic              head_new, la_new;
    logic [ID_W-1:0]   head_id, la_id;
    logic [CLK_W-1:0]  head_st, la_st;
    logic              hit, due;
    logic [CLK_W-1:0]  age;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    assign cnt_l     = LW'(r_count);
    assign step_l    = LW'(r_step);
    assign step1_l   = step_l + LW'(1);
    assign app_l     = LW'(r_app_pos);
    assign cnt_inc_l = cnt_l + LW'(1);
    assign cnt_dec_l = cnt_l - LW'(1);
    assign lim_l     = (LW'(r_win) < DEPTH_L) ? LW'(r_win) : DEPTH_L;
    assign past_last = r_next > {1'b0, r_last_id};
    assign can_app   = (cnt_l < lim_l) && !past_last;
    assign in_use    = step_l < cnt_l;
    assign pass_end  = r_step == STEP_LAST;

    // the entry being appended sits virtually at slot app_pos of the stream
    assign head_new = r_app && (step_l == app_l);
    assign la_new   = r_app && (step1_l == app_l);
    assign head_id  = head_new ? r_new_id : r_eid[0];
    assign head_st  = head_new ? r_clock  : r_est[0];
    assign la_id    = la_new   ? r_new_id : r_eid[LA];
    assign la_st    = la_new   ? r_clock  : r_est[LA];

    assign hit = r_mode && !r_drop && in_use && (head_id == r_rid);
    assign age = r_clock - r_est[0];
    assign due = in_use && (age >= CLK_W'(r_tmo));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (can_app) begin
                        n_state = S_NEW;
                    end else if (r_count != '0) begin
                        n_state = i_in_mode ? S_P1 : S_P2;
                    end else begin
                        n_state = S_STAT;
                    end
                end
            end
            S_NEW: begin
                if (out_free) begin
                    n_state = S_P1;
                end
            end
            S_P1: begin
                if (pass_end) begin
                    n_state = (r_drop || hit) ? S_ACC : S_P2;
                end
            end
            S_ACC: begin
                if (out_free) begin
                    n_state = (cnt_dec_l != '0) ? S_P2 : S_STAT;
                end
            end
            S_P2: begin
                if (pass_end && (!due || out_free)) begin
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_in_stall = 1'b1;
        n_clock    = r_clock;
        n_next     = r_next;
        n_count    = r_count;
        n_app      = r_app;
        n_app_pos  = r_app_pos;
        n_new_id   = r_new_id;
        n_mode     = r_mode;
        n_rid      = r_rid;
        n_step     = r_step;
        n_drop     = r_drop;
        rot        = 1'b0;
        tail_id    = head_id;
        tail_st    = head_st;
        emit       = 1'b0;
        e_kind     = KIND_STAT;
        e_id       = '0;
        e_cnt      = cnt_l[CNT_W-1:0];
        e_done     = 1'b0;
        e_last     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                n_step     = '0;
                n_drop     = 1'b0;
                if (accept) begin
                    n_clock   = r_clock + CLK_W'(i_in_elapsed_ticks);
                    n_app     = can_app;
                    n_app_pos = r_count;
                    n_new_id  = r_next[ID_W-1:0];
                    n_mode    = i_in_mode;
                    n_rid     = i_in_response_id;
                end
            end
            S_NEW: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_NEW;
                    e_id    = r_new_id;
                    e_cnt   = cnt_inc_l[CNT_W-1:0];
                    n_count = cnt_inc_l[CW-1:0];
                    n_next  = r_next + NEXT_W'(1);
                end
            end
            S_P1: begin
                // append and removal in one rotation; after a match each slot
                // takes its successor so the tail closes up
                rot    = 1'b1;
                n_drop = r_drop || hit;
                if (r_drop || hit) begin
                    tail_id = la_id;
                    tail_st = la_st;
                end
                n_step = pass_end ? '0 : r_step + TW'(1);
            end
            S_ACC: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_ACC;
                    e_id    = r_rid;
                    e_cnt   = cnt_dec_l[CNT_W-1:0];
                    e_done  = past_last && (cnt_dec_l == '0);
                    n_count = cnt_dec_l[CW-1:0];
                end
            end
            S_P2: begin
                // timeout scan; a due entry waits for the output register
                tail_id = r_eid[0];
                tail_st = due ? r_clock : r_est[0];
                if (!due || out_free) begin
                    rot    = 1'b1;
                    n_step = pass_end ? '0 : r_step + TW'(1);
                    if (due) begin
                        emit   = 1'b1;
                        e_kind = KIND_RE;
                        e_id   = r_eid[0];
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = KIND_STAT;
                    e_done = past_last && (r_count == '0);
                    e_last = 1'b1;
                end
            end
            default: ;
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock     <= '0;
            r_next      <= '0;
            r_count     <= '0;
            r_app       <= 1'b0;
            r_mode      <= 1'b0;
            r_step      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_id   <= RST_LAST_ID;
            r_win       <= RST_WINDOW;
            r_tmo       <= RST_TIMEOUT;
        end else begin
            r_state     <= n_state;
            r_clock     <= n_clock;
            r_next      <= n_next;
            r_count     <= n_count;
            r_app       <= n_app;
            r_mode      <= n_mode;
            r_step      <= n_step;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_LAST_ID: r_last_id <= pwdata[ID_W-1:0];
                    REG_WINDOW:  r_win     <= pwdata[CNT_W-1:0];
                    REG_TIMEOUT: r_tmo     <= pwdata[TICK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_app_pos <= n_app_pos;
        r_new_id  <= n_new_id;
        r_rid     <= n_rid;
        if (emit) begin
            r_out_kind <= e_kind;
            r_out_id   <= e_id;
            r_out_cnt  <= e_cnt;
            r_out_done <= e_done;
            r_out_last <= e_last;
        end
        if (rot) begin
            for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
                r_eid[k] <= r_eid[k + 1];
                r_est[k] <= r_est[k + 1];
            end
            r_eid[WINDOW_DEPTH - 1] <= tail_id;
            r_est[WINDOW_DEPTH - 1] <= tail_st;
        end
    end

    // register read-back
    always_comb begin
        case (paddr[3:2])
            REG_LAST_ID: prdata = {16'b0, r_last_id};
            REG_WINDOW:  prdata = {27'b0, r_win};
            REG_TIMEOUT: prdata = {16'b0, r_tmo};
            default:     prdata = '0;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_kind        = r_out_kind;
    assign o_out_chunk_id    = r_out_id;
    assign o_out_outstanding = r_out_cnt;
    assign o_out_done_res    = r_out_done;
    assign o_out_last        = r_out_last;

endmodule
